>>> hdl/tbs_pkg.sv
// ---------------------------------------------------------------------------
// tbs_pkg
// shared types and constants for the monotone time table bracket search
// ---------------------------------------------------------------------------
package tbs_pkg;

  // fixed field widths of the request and result channels
  localparam int TIME_W        = 32;
  localparam int IDX_W         = 10;
  localparam int CNT_W         = 11;
  localparam int DEFAULT_DEPTH = 1024;

  // request codes; the fourth code leaves the table unchanged and returns status OK
  typedef enum logic [1:0] {
    REQ_APPEND = 2'd0,
    REQ_LOOKUP = 2'd1,
    REQ_CLEAR  = 2'd2
  } tbs_req_t;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_EMPTY    = 2'd1,
    STATUS_REVERSED = 2'd2,
    STATUS_FULL     = 2'd3
  } tbs_status_t;

  typedef struct packed {
    logic [1:0]               req_type;
    logic signed [TIME_W-1:0] time_value;
  } tbs_in_t;

  typedef struct packed {
    tbs_status_t      status;
    logic [IDX_W-1:0] lower_index;
    logic [IDX_W-1:0] upper_index;
    logic [IDX_W-1:0] nearest_index;
    logic [CNT_W-1:0] entry_count;
  } tbs_out_t;

endpackage

>>> hdl/tbs_table_ram.sv
// ---------------------------------------------------------------------------
// tbs_table_ram
// time table storage, one write port and one registered read port
// ---------------------------------------------------------------------------
module tbs_table_ram #(
  parameter int TABLE_DEPTH = tbs_pkg::DEFAULT_DEPTH
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [$clog2(TABLE_DEPTH)-1:0]         wr_addr,
  input  logic [tbs_pkg::TIME_W-1:0]             wr_data,
  input  logic                                   rd_en,
  input  logic [$clog2(TABLE_DEPTH)-1:0]         rd_addr,
  output logic [tbs_pkg::TIME_W-1:0]             rd_data
);
  import tbs_pkg::*;

  logic [TIME_W-1:0] mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hdl/tbs_ctrl.sv
// ---------------------------------------------------------------------------
// tbs_ctrl
// request sequencer: append check, binary search and bracket selection
// ---------------------------------------------------------------------------
module tbs_ctrl #(
  parameter int TABLE_DEPTH = tbs_pkg::DEFAULT_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  output logic                            req_ready,
  input  tbs_pkg::tbs_in_t                req_data,
  output logic                            rslt_valid,
  output tbs_pkg::tbs_out_t               rslt,
  input  logic                            rslt_taken,
  output logic                            mem_wr_en,
  output logic [$clog2(TABLE_DEPTH)-1:0]  mem_wr_addr,
  output logic [tbs_pkg::TIME_W-1:0]      mem_wr_data,
  output logic                            mem_rd_en,
  output logic [$clog2(TABLE_DEPTH)-1:0]  mem_rd_addr,
  input  logic [tbs_pkg::TIME_W-1:0]      mem_rd_data
);
  import tbs_pkg::*;

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_AP_LAST,
    S_AP_CHK,
    S_LK_FIRST,
    S_LK_DIR,
    S_SRCH,
    S_BRK,
    S_BRK_LO,
    S_BRK_HI,
    S_NEAR,
    S_DONE
  } state_t;

  state_t            state, state_next;
  logic [CW-1:0]     cnt, cnt_next;
  logic [TIME_W-1:0] q_key, q_key_next;
  logic [TIME_W-1:0] key_a, key_a_next;
  logic              dir_fall, dir_fall_next;
  logic [CW-1:0]     lo_b, lo_b_next;
  logic [CW-1:0]     hi_b, hi_b_next;
  logic [IW-1:0]     mid_idx, mid_idx_next;
  logic [IW-1:0]     brk_lo, brk_lo_next;
  logic [IW-1:0]     brk_hi, brk_hi_next;
  logic [IW-1:0]     near_idx, near_idx_next;
  logic [TIME_W-1:0] dist_lo, dist_lo_next;
  logic [TIME_W-1:0] dist_hi, dist_hi_next;
  tbs_status_t       rs_status, rs_status_next;

  logic [TIME_W-1:0] in_key;
  logic [CW-1:0]     cnt_dec, cnt_dec2, cnt_half, lo_dec;
  logic [CW-1:0]     mid_ext, lo_n, hi_n, mid_n;
  logic              probe_ahead, reversed;
  logic [TIME_W-1:0] key_dist;

  // offset binary: unsigned order equals signed order
  assign in_key   = {~req_data.time_value[TIME_W-1], req_data.time_value[TIME_W-2:0]};
  assign cnt_dec  = cnt - CW'(1);
  assign cnt_dec2 = cnt - CW'(2);
  assign cnt_half = cnt >> 1;
  assign lo_dec   = lo_b - CW'(1);
  assign mid_ext  = CW'(mid_idx);

  // search step on the entry read at mid
  assign probe_ahead = dir_fall ? (mem_rd_data > q_key) : (mem_rd_data < q_key);
  assign lo_n   = probe_ahead ? (mid_ext + CW'(1)) : lo_b;
  assign hi_n   = probe_ahead ? hi_b : mid_ext;
  assign mid_n  = lo_n + ((hi_n - lo_n) >> 1);

  // key_a holds entry n-1, the read data entry n-2
  assign reversed = ((key_a > mem_rd_data) && (q_key < key_a)) ||
                    ((key_a < mem_rd_data) && (q_key > key_a));

  assign key_dist = (q_key >= mem_rd_data) ? (q_key - mem_rd_data) : (mem_rd_data - q_key);

  assign req_ready  = (state == S_IDLE);
  assign rslt_valid = (state == S_DONE);

  always_comb begin
    rslt.status        = rs_status;
    rslt.lower_index   = IDX_W'(brk_lo);
    rslt.upper_index   = IDX_W'(brk_hi);
    rslt.nearest_index = IDX_W'(near_idx);
    rslt.entry_count   = CNT_W'(cnt);
  end

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    q_key_next     = q_key;
    key_a_next     = key_a;
    dir_fall_next  = dir_fall;
    lo_b_next      = lo_b;
    hi_b_next      = hi_b;
    mid_idx_next   = mid_idx;
    brk_lo_next    = brk_lo;
    brk_hi_next    = brk_hi;
    near_idx_next  = near_idx;
    dist_lo_next   = dist_lo;
    dist_hi_next   = dist_hi;
    rs_status_next = rs_status;
    mem_rd_en      = 1'b0;
    mem_rd_addr    = '0;
    mem_wr_en      = 1'b0;
    mem_wr_addr    = cnt[IW-1:0];
    mem_wr_data    = q_key;

    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          q_key_next     = in_key;
          brk_lo_next    = '0;
          brk_hi_next    = '0;
          near_idx_next  = '0;
          rs_status_next = STATUS_OK;
          state_next     = S_DONE;
          unique case (req_data.req_type)
            REQ_APPEND: begin
              if (cnt >= CW'(TABLE_DEPTH)) begin
                rs_status_next = STATUS_FULL;
              end else if (cnt >= CW'(2)) begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = cnt_dec[IW-1:0];
                state_next  = S_AP_LAST;
              end else begin
                mem_wr_en   = 1'b1;
                mem_wr_data = in_key;
                cnt_next    = cnt + CW'(1);
              end
            end
            REQ_LOOKUP: begin
              if (cnt == '0) begin
                rs_status_next = STATUS_EMPTY;
              end else if (cnt >= CW'(2)) begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = '0;
                state_next  = S_LK_FIRST;
              end
            end
            REQ_CLEAR: begin
              cnt_next = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_AP_LAST: begin
        key_a_next  = mem_rd_data;
        mem_rd_en   = 1'b1;
        mem_rd_addr = cnt_dec2[IW-1:0];
        state_next  = S_AP_CHK;
      end
      S_AP_CHK: begin
        if (reversed) begin
          rs_status_next = STATUS_REVERSED;
        end else begin
          mem_wr_en = 1'b1;
          cnt_next  = cnt + CW'(1);
        end
        state_next = S_DONE;
      end
      S_LK_FIRST: begin
        key_a_next  = mem_rd_data;
        mem_rd_en   = 1'b1;
        mem_rd_addr = IW'(1);
        state_next  = S_LK_DIR;
      end
      S_LK_DIR: begin
        dir_fall_next = key_a > mem_rd_data;
        lo_b_next     = '0;
        hi_b_next     = cnt;
        mid_idx_next  = cnt_half[IW-1:0];
        mem_rd_en     = 1'b1;
        mem_rd_addr   = cnt_half[IW-1:0];
        state_next    = S_SRCH;
      end
      S_SRCH: begin
        lo_b_next = lo_n;
        hi_b_next = hi_n;
        if (lo_n < hi_n) begin
          mid_idx_next = mid_n[IW-1:0];
          mem_rd_en    = 1'b1;
          mem_rd_addr  = mid_n[IW-1:0];
        end else begin
          state_next = S_BRK;
        end
      end
      S_BRK: begin
        if (lo_b == '0) begin
          brk_lo_next = '0;
          brk_hi_next = '0;
        end else if (lo_b == cnt) begin
          brk_lo_next = cnt_dec[IW-1:0];
          brk_hi_next = cnt_dec[IW-1:0];
        end else begin
          brk_lo_next = lo_dec[IW-1:0];
          brk_hi_next = lo_b[IW-1:0];
        end
        mem_rd_en   = 1'b1;
        mem_rd_addr = brk_lo_next;
        state_next  = S_BRK_LO;
      end
      S_BRK_LO: begin
        dist_lo_next = key_dist;
        mem_rd_en    = 1'b1;
        mem_rd_addr  = brk_hi;
        state_next   = S_BRK_HI;
      end
      S_BRK_HI: begin
        dist_hi_next = key_dist;
        state_next   = S_NEAR;
      end
      S_NEAR: begin
        // a tie goes to the upper entry
        near_idx_next = (dist_lo < dist_hi) ? brk_lo : brk_hi;
        state_next    = S_DONE;
      end
      S_DONE: begin
        if (rslt_taken) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
    q_key     <= q_key_next;
    key_a     <= key_a_next;
    dir_fall  <= dir_fall_next;
    lo_b      <= lo_b_next;
    hi_b      <= hi_b_next;
    mid_idx   <= mid_idx_next;
    brk_lo    <= brk_lo_next;
    brk_hi    <= brk_hi_next;
    near_idx  <= near_idx_next;
    dist_lo   <= dist_lo_next;
    dist_hi   <= dist_hi_next;
    rs_status <= rs_status_next;
  end

endmodule

>>> hdl/monotone_time_table_bracket_search.sv
// ---------------------------------------------------------------------------
// monotone_time_table_bracket_search
// monotone time table with append, clear and lower-bound bracket lookup
// ---------------------------------------------------------------------------
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------
//  request | req_valid, req_ready | req_data  (req_type, time_value)
//  result  | res_valid, res_ready | res_data  (status, lower/upper/nearest
//          |                      |            index, entry_count)
//
//  one request at a time; a lookup on n >= 2 entries reads entries 0 and 1
//  for the direction, runs the binary search and reads both bracket entries;
//  an append on two or more entries first reads the last two entries
//  requests are paced by the single read port of the table memory, one read
//  a cycle, and by the binary search issuing one read per step
//  reset (synchronous, active high) empties the table; the memory itself is
//  not cleared, entries at or above the count are never read
//  a result waits in the output register while res_ready is low; a finished
//  request holds the sequencer until its result has moved there
// ---------------------------------------------------------------------------
module monotone_time_table_bracket_search #(
  parameter int TABLE_DEPTH = tbs_pkg::DEFAULT_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  tbs_pkg::tbs_in_t   req_data,
  output logic               res_valid,
  input  logic               res_ready,
  output tbs_pkg::tbs_out_t  res_data
);
  import tbs_pkg::*;

  localparam int IW = $clog2(TABLE_DEPTH);

  // sequencer to output register
  logic     rslt_valid;
  logic     rslt_taken;
  tbs_out_t rslt;
  logic     slot_free;

  // table memory ports
  logic              mem_wr_en;
  logic [IW-1:0]     mem_wr_addr;
  logic [TIME_W-1:0] mem_wr_data;
  logic              mem_rd_en;
  logic [IW-1:0]     mem_rd_addr;
  logic [TIME_W-1:0] mem_rd_data;

  tbs_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .req_data    (req_data),
    .rslt_valid  (rslt_valid),
    .rslt        (rslt),
    .rslt_taken  (rslt_taken),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data)
  );

  tbs_table_ram #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_table_ram (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // output register: free when empty or being drained this cycle
  assign slot_free  = !res_valid || res_ready;
  assign rslt_taken = rslt_valid && slot_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (rslt_taken) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
    if (rslt_taken) begin
      res_data <= rslt;
    end
  end

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------

  // a request in flight blocks the next one
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("request accepted while another is in flight");

  // the count never runs past the table
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (int'(res_data.entry_count) <= TABLE_DEPTH))
    else $error("entry count beyond table depth");

  // bracket entries are equal or adjacent, nearest is one of them
  a_bracket: assert property (@(posedge clk) disable iff (rst)
    (res_valid && (res_data.status == STATUS_OK)) |->
      ((res_data.upper_index == res_data.lower_index) ||
       (res_data.upper_index == res_data.lower_index + IDX_W'(1))) &&
      ((res_data.nearest_index == res_data.lower_index) ||
       (res_data.nearest_index == res_data.upper_index)))
    else $error("bracket pair inconsistent");

endmodule
